@@ sv/kfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kfr_pkg;

  // Limits and widths
  localparam int unsigned MAX_LEN   = 4096;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Framing bytes
  localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
  localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
  localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
  localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_TYPE = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]  MAX_PAYLOAD_RST = 13'd256;
  localparam logic [BYTE_W-1:0] LOCAL_TYPE_RST  = 8'h00;
  localparam logic [BYTE_W-1:0] REMOTE_TYPE_RST = 8'h01;

  typedef enum logic [1:0] {
    EV_DATA = 2'd0,
    EV_DONE = 2'd1,
    EV_ERR  = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_TYPE  = 3'd1,
    ERR_ESC   = 3'd2,
    ERR_OVF   = 3'd3,
    ERR_STRAY = 3'd4
  } err_t;

  // One classified byte as it travels from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fend;
    logic              fesc;
    logic              tfend;
    logic              tfesc;
    logic              is_local;
    logic              is_remote;
  } cls_t;

endpackage
`default_nettype wire

@@ sv/kfr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kfr_front import kfr_pkg::*; (
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] local_type,
  input  wire logic [BYTE_W-1:0] remote_type,
  output cls_t                   cls
);

  // Tag the byte with every comparison the back end needs
  always_comb begin
    cls.data      = rx_byte;
    cls.fend      = (rx_byte == FEND);
    cls.fesc      = (rx_byte == FESC);
    cls.tfend     = (rx_byte == TFEND);
    cls.tfesc     = (rx_byte == TFESC);
    cls.is_local  = (rx_byte == local_type);
    cls.is_remote = (rx_byte == remote_type);
  end

endmodule
`default_nettype wire

@@ sv/kfr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kfr_queue import kfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cls_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cls_t      head_data
);

  cls_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ sv/kfr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kfr_back import kfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CNT_W-1:0]  max_payload,
  input  wire logic              head_valid,
  input  wire cls_t              head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_event_res,
  output logic [BYTE_W-1:0]      out_data_byte,
  output logic [BYTE_W-1:0]      out_frame_type,
  output logic                   out_is_remote,
  output logic [CNT_W-1:0]       out_byte_count,
  output logic [2:0]             out_error_kind
);

  // Deframer state
  logic              in_frame_r, in_frame_nxt;
  logic              type_seen_r, type_seen_nxt;
  logic              esc_r, esc_nxt;
  logic              remote_r, remote_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  event_t            ev_r, ev_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [BYTE_W-1:0] ftype_r, ftype_nxt;
  logic              rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  err_t              err_r, err_nxt;

  logic              emit;
  logic [BYTE_W-1:0] byte_val;
  logic [CNT_W-1:0]  limit;
  logic              go;

  assign limit = (max_payload > CNT_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : max_payload;
  assign go    = head_valid && (!out_valid_r || out_ready);
  assign pop   = go;

  // Work out one byte's effect on the frame state
  always_comb begin
    in_frame_nxt  = in_frame_r;
    type_seen_nxt = type_seen_r;
    esc_nxt       = esc_r;
    remote_nxt    = remote_r;
    type_nxt      = type_r;
    count_nxt     = count_r;
    emit          = 1'b0;
    byte_val      = head_data.data;
    ev_nxt        = EV_ERR;
    data_nxt      = '0;
    ftype_nxt     = type_r;
    rem_nxt       = remote_r;
    cnt_nxt       = count_r;
    err_nxt       = ERR_NONE;

    if (!in_frame_r) begin
      if (head_data.fend) begin
        in_frame_nxt  = 1'b1;
        type_seen_nxt = 1'b0;
        esc_nxt       = 1'b0;
        count_nxt     = '0;
      end else begin
        emit      = 1'b1;
        ftype_nxt = '0;
        rem_nxt   = 1'b0;
        cnt_nxt   = '0;
        err_nxt   = ERR_STRAY;
      end
    end else if (!type_seen_r) begin
      if (head_data.is_local) begin
        type_seen_nxt = 1'b1;
        remote_nxt    = 1'b0;
        type_nxt      = head_data.data;
      end else if (head_data.is_remote) begin
        type_seen_nxt = 1'b1;
        remote_nxt    = 1'b1;
        type_nxt      = head_data.data;
      end else if (!head_data.fend) begin
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        emit         = 1'b1;
        ftype_nxt    = head_data.data;
        rem_nxt      = 1'b0;
        cnt_nxt      = '0;
        err_nxt      = ERR_TYPE;
      end
    end else if (head_data.fend && (count_r != '0)) begin
      // Close a frame that carries payload
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      emit         = 1'b1;
      ev_nxt       = EV_DONE;
    end else if (head_data.fend && !esc_r) begin
      // Skip the FEND of an empty frame
    end else if (!esc_r && head_data.fesc) begin
      esc_nxt = 1'b1;
    end else if (esc_r && !head_data.tfend && !head_data.tfesc) begin
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      emit         = 1'b1;
      err_nxt      = ERR_ESC;
    end else begin
      if (esc_r) begin
        esc_nxt  = 1'b0;
        byte_val = head_data.tfend ? FEND : FESC;
      end
      emit = 1'b1;
      if (count_r >= limit) begin
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        err_nxt      = ERR_OVF;
      end else begin
        count_nxt = count_r + 1'b1;
        cnt_nxt   = count_r + 1'b1;
        ev_nxt    = EV_DATA;
        data_nxt  = byte_val;
      end
    end

    if (go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      type_seen_r <= 1'b0;
      esc_r       <= 1'b0;
      remote_r    <= 1'b0;
      type_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        in_frame_r  <= in_frame_nxt;
        type_seen_r <= type_seen_nxt;
        esc_r       <= esc_nxt;
        remote_r    <= remote_nxt;
        type_r      <= type_nxt;
        count_r     <= count_nxt;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (go && emit) begin
      ev_r    <= ev_nxt;
      data_r  <= data_nxt;
      ftype_r <= ftype_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = ev_r;
  assign out_data_byte  = data_r;
  assign out_frame_type = ftype_r;
  assign out_is_remote  = rem_r;
  assign out_byte_count = cnt_r;
  assign out_error_kind = err_r;

endmodule
`default_nettype wire

@@ sv/kiss_frame_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// KISS/SLIP frame receiver. One received byte enters per item and each item
// yields at most one result: a payload byte, a frame-complete count or an
// error. The block sustains one item per clock while results are taken. A
// byte is classified combinationally as it is accepted into a two-entry
// queue; the back end takes the queue head, updates the frame state and
// loads the output register. The frame state update in the back end sets
// that rate; a held result stalls the back end, and the queue then fills and
// drops in_ready. The user must write registers through the cfg_ port only
// while no item is in flight; the block itself does not enforce this.
module kiss_frame_receiver import kfr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_event_res,
  output logic [BYTE_W-1:0]         out_data_byte,
  output logic [BYTE_W-1:0]         out_frame_type,
  output logic                      out_is_remote,
  output logic [CNT_W-1:0]          out_byte_count,
  output logic [2:0]                out_error_kind,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CNT_W-1:0]  max_payload_r;
  logic [BYTE_W-1:0] local_type_r;
  logic [BYTE_W-1:0] remote_type_r;

  cls_t front_cls;
  cls_t head_data;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      local_type_r  <= LOCAL_TYPE_RST;
      remote_type_r <= REMOTE_TYPE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_MAX_PAYLOAD: max_payload_r <= cfg_data[CNT_W-1:0];
        REG_LOCAL_TYPE:  local_type_r  <= cfg_data[BYTE_W-1:0];
        REG_REMOTE_TYPE: remote_type_r <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  kfr_front u_front (
    .rx_byte     (in_rx_byte),
    .local_type  (local_type_r),
    .remote_type (remote_type_r),
    .cls         (front_cls)
  );

  kfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_data  (front_cls),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  kfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_payload    (max_payload_r),
    .head_valid     (q_valid),
    .head_data      (head_data),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_data_byte  (out_data_byte),
    .out_frame_type (out_frame_type),
    .out_is_remote  (out_is_remote),
    .out_byte_count (out_byte_count),
    .out_error_kind (out_error_kind)
  );

endmodule
`default_nettype wire

@@ sim/kfr_checker.sv @@
`timescale 1ns / 1ps
module kfr_checker import kfr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [1:0]           out_event_res,
  input  wire logic [BYTE_W-1:0]    out_data_byte,
  input  wire logic [BYTE_W-1:0]    out_frame_type,
  input  wire logic                 out_is_remote,
  input  wire logic [CNT_W-1:0]     out_byte_count,
  input  wire logic [2:0]           out_error_kind,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    event_t            ev;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] ftype;
    logic              remote;
    logic [CNT_W-1:0]  count;
    err_t              err;
  } deframe_result_t;

  deframe_result_t predicted_events[$];
  int failures = 0;

  // Register copies
  logic [CNT_W-1:0]  max_payload;
  logic [BYTE_W-1:0] local_type;
  logic [BYTE_W-1:0] remote_type;

  // Deframer state
  logic              in_frame;
  logic              type_seen;
  logic              esc_pend;
  logic              remote_flag;
  logic [BYTE_W-1:0] type_val;
  logic [CNT_W-1:0]  pay_cnt;

  task automatic record(input event_t ev, input logic [BYTE_W-1:0] data,
                        input logic [BYTE_W-1:0] ftype, input logic remote,
                        input logic [CNT_W-1:0] count, input err_t err);
    deframe_result_t r;
    r.ev     = ev;
    r.data   = data;
    r.ftype  = ftype;
    r.remote = remote;
    r.count  = count;
    r.err    = err;
    predicted_events.push_back(r);
  endtask

  // Leave the frame and report the error against its current state
  task automatic abort_frame(input err_t err);
    in_frame = 1'b0;
    esc_pend = 1'b0;
    record(EV_ERR, '0, type_val, remote_flag, pay_cnt, err);
  endtask

  // Advance the deframer by one received byte
  task automatic deframe_byte(input logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] b;
    logic [CNT_W-1:0]  lim;
    b   = rx;
    lim = (max_payload > MAX_LEN) ? CNT_W'(MAX_LEN) : max_payload;
    if (!in_frame) begin
      if (b == FEND) begin
        in_frame  = 1'b1;
        type_seen = 1'b0;
        esc_pend  = 1'b0;
        pay_cnt   = '0;
      end else begin
        record(EV_ERR, '0, '0, 1'b0, '0, ERR_STRAY);
      end
    end else if (!type_seen) begin
      // local is compared first, then remote, and only then FEND
      if (b == local_type) begin
        type_seen   = 1'b1;
        remote_flag = 1'b0;
        type_val    = b;
      end else if (b == remote_type) begin
        type_seen   = 1'b1;
        remote_flag = 1'b1;
        type_val    = b;
      end else if (b != FEND) begin
        in_frame = 1'b0;
        esc_pend = 1'b0;
        record(EV_ERR, '0, b, 1'b0, '0, ERR_TYPE);
      end
    end else if (b == FEND && pay_cnt != 0) begin
      // a pending escape is dropped by the closing FEND
      in_frame = 1'b0;
      esc_pend = 1'b0;
      record(EV_DONE, '0, type_val, remote_flag, pay_cnt, ERR_NONE);
    end else if (b == FEND && !esc_pend) begin
      // empty frame: ignore the FEND
    end else if (!esc_pend && b == FESC) begin
      esc_pend = 1'b1;
    end else if (esc_pend && b != TFEND && b != TFESC) begin
      abort_frame(ERR_ESC);
    end else begin
      if (esc_pend) b = (b == TFEND) ? FEND : FESC;
      esc_pend = 1'b0;
      if (pay_cnt >= lim) begin
        abort_frame(ERR_OVF);
      end else begin
        pay_cnt = pay_cnt + 1'b1;
        record(EV_DATA, b, type_val, remote_flag, pay_cnt, ERR_NONE);
      end
    end
  endtask

  function automatic bit field_ok(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    deframe_result_t want;
    bit ok;
    if (!rst_n) begin
      max_payload = MAX_PAYLOAD_RST;
      local_type  = LOCAL_TYPE_RST;
      remote_type = REMOTE_TYPE_RST;
      in_frame    = 1'b0;
      type_seen   = 1'b0;
      esc_pend    = 1'b0;
      remote_flag = 1'b0;
      type_val    = '0;
      pay_cnt     = '0;
      predicted_events.delete();
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_MAX_PAYLOAD: max_payload = cfg_data;
          REG_LOCAL_TYPE:  local_type  = cfg_data[BYTE_W-1:0];
          REG_REMOTE_TYPE: remote_type = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      // Compare each result with the oldest prediction
      if (out_valid && out_ready) begin
        if (predicted_events.size() == 0) begin
          $error("unexpected result: event %0d, error kind %0d", out_event_res,
                 out_error_kind);
          failures++;
        end else begin
          want = predicted_events.pop_front();
          ok = 1'b1;
          ok &= field_ok("event_res", int'(want.ev), int'(out_event_res));
          ok &= field_ok("data_byte", int'(want.data), int'(out_data_byte));
          ok &= field_ok("frame_type", int'(want.ftype), int'(out_frame_type));
          ok &= field_ok("is_remote", int'(want.remote), int'(out_is_remote));
          ok &= field_ok("byte_count", int'(want.count), int'(out_byte_count));
          ok &= field_ok("error_kind", int'(want.err), int'(out_error_kind));
          if (!ok) failures++;
        end
      end
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
    end
    outstanding <= predicted_events.size();
    fail_count  <= failures;
  end

endmodule

@@ sim/tb_kiss_frame_receiver.sv @@
`timescale 1ns / 1ps
module tb_kiss_frame_receiver;
  import kfr_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_event_res;
  logic [BYTE_W-1:0]    out_data_byte;
  logic [BYTE_W-1:0]    out_frame_type;
  logic                 out_is_remote;
  logic [CNT_W-1:0]     out_byte_count;
  logic [2:0]           out_error_kind;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;
  logic stall_on;

  // Register values as last written, used to shape the stimulus
  int          cur_max    = int'(MAX_PAYLOAD_RST);
  logic [7:0]  cur_local  = LOCAL_TYPE_RST;
  logic [7:0]  cur_remote = REMOTE_TYPE_RST;

  kiss_frame_receiver i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_data_byte  (out_data_byte),
    .out_frame_type (out_frame_type),
    .out_is_remote  (out_is_remote),
    .out_byte_count (out_byte_count),
    .out_error_kind (out_error_kind),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data)
  );

  kfr_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_data_byte  (out_data_byte),
    .out_frame_type (out_frame_type),
    .out_is_remote  (out_is_remote),
    .out_byte_count (out_byte_count),
    .out_error_kind (out_error_kind),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side in short random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one byte, with an optional idle burst first, and hold until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Send one payload byte with the escaping that the line needs
  task automatic send_escaped(input logic [BYTE_W-1:0] b);
    if (b == FEND) begin
      send_byte(FESC);
      send_byte(TFEND);
    end else if (b == FESC) begin
      send_byte(FESC);
      send_byte(TFESC);
    end else begin
      send_byte(b);
    end
  endtask

  // Hold the sender until every predicted result is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_MAX_PAYLOAD: cur_max    = value;
      REG_LOCAL_TYPE:  cur_local  = value[7:0];
      REG_REMOTE_TYPE: cur_remote = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int max_pay, input int loc, input int rem);
    write_reg(REG_MAX_PAYLOAD, max_pay);
    write_reg(REG_LOCAL_TYPE, loc);
    write_reg(REG_REMOTE_TYPE, rem);
    cfg_wr_en <= 1'b0;
  endtask

  // One frame with random content, now and then broken or left open
  task automatic send_frame();
    int len;
    int pick;
    logic [BYTE_W-1:0] ftype;
    send_byte(FEND);
    if ($urandom_range(0, 3) == 0) send_byte(FEND);
    pick = $urandom_range(0, 9);
    if (pick < 6) ftype = cur_local;
    else if (pick < 9) ftype = cur_remote;
    else ftype = BYTE_W'($urandom_range(0, 255));
    send_byte(ftype);
    if (cur_max <= 40 && $urandom_range(0, 3) == 0) len = $urandom_range(0, cur_max + 2);
    else len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_byte(FESC);
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        send_escaped(pick[0] ? FEND : FESC);
      end else begin
        send_escaped(BYTE_W'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(FEND);
  endtask

  task automatic send_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_frame();
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_idx    <= '0;
    cfg_data   <= '0;
    stall_on   <= 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: stray bytes, skipped FENDs, escapes, empty and broken frames
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(FEND);
    send_byte(FEND);
    send_byte(LOCAL_TYPE_RST);
    send_byte(FEND);
    send_byte(FESC);
    send_byte(TFEND);
    send_byte(FESC);
    send_byte(TFESC);
    send_byte(8'h00);
    send_byte(FEND);
    send_byte(FEND);
    send_byte(REMOTE_TYPE_RST);
    send_byte(FESC);
    send_byte(FEND);
    send_byte(FEND);
    send_byte(8'h05);
    send_byte(FEND);
    send_byte(REMOTE_TYPE_RST);
    send_byte(8'h7A);
    send_byte(FESC);
    send_byte(8'h41);
    send_byte(FEND);
    send_byte(LOCAL_TYPE_RST);
    send_byte(8'h33);
    send_byte(FESC);
    send_byte(FEND);
    send_random(400);
    drain();

    // One-byte limit with FEND as the local type
    configure(1, int'(FEND), int'(FESC));
    send_byte(FEND);
    send_byte(FEND);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(FEND);
    send_byte(FESC);
    send_byte(8'h44);
    send_byte(FEND);
    send_random(200);
    drain();

    // Zero limit, local and remote equal
    configure(0, 'h5A, 'h5A);
    send_byte(FEND);
    send_byte(8'h5A);
    send_byte(8'h10);
    send_random(150);
    drain();

    // Limit above the length cap
    write_reg(REG_SPARE, 8191);
    configure(8191, 'h7E, 'h81);
    send_byte(FEND);
    send_byte(8'h81);
    send_random(150);
    drain();

    configure(MAX_LEN, $urandom_range(0, 255), $urandom_range(0, 255));
    send_random(200);
    drain();

    configure($urandom_range(2, 40), $urandom_range(0, 255), $urandom_range(0, 255));
    send_random(200);
    // Last stretch runs without idling on either side
    idle_on = 1'b0;
    stall_on <= 1'b0;
    send_random(200);
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/kfr_pkg.sv
sv/kfr_front.sv
sv/kfr_queue.sv
sv/kfr_back.sv
sv/kiss_frame_receiver.sv
sim/kfr_checker.sv
sim/tb_kiss_frame_receiver.sv
